### design/dpfa_pkg.sv
// ----------------------------------------------------------------------------
// Demand paging frame allocator package
// Shared sizes, codes and the page table entry type.
// ----------------------------------------------------------------------------
package dpfa_pkg;

	localparam int PROCESS_SLOTS  = 8;
	localparam int PAGE_BYTES     = 32;
	localparam int VIRTUAL_BYTES  = 1024;
	localparam int PHYSICAL_BYTES = 1024;

	localparam int VPAGES   = (VIRTUAL_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
	localparam int FRAMES   = PHYSICAL_BYTES / PAGE_BYTES;
	localparam int ENTRIES  = PROCESS_SLOTS * VPAGES;
	localparam int SLOT_W   = $clog2(PROCESS_SLOTS);
	localparam int PAGE_W   = $clog2(VPAGES);
	localparam int FRAME_W  = $clog2(FRAMES);
	localparam int OFF_W    = $clog2(PAGE_BYTES);
	localparam int ENT_AW   = $clog2(ENTRIES);
	localparam int PHYS_AW  = $clog2(PHYSICAL_BYTES);

	// Command codes.
	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_WRITE  = 2'd2;
	localparam logic [1:0] CMD_EXIT   = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// One page table entry as stored in the entry memory.
	typedef struct packed {
		logic               present;
		logic [FRAME_W-1:0] frame;
	} entry_t;

endpackage

### design/dpfa_ram.sv
// ----------------------------------------------------------------------------
// Demand paging frame allocator RAM
// Generic simple dual port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dpfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/demand_paging_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// Demand paging frame allocator unit
// Per-process page tables with first-fit frame allocation on demand.
// ----------------------------------------------------------------------------
// A command rejected in idle is answered without leaving idle.
// Create and exit walk the 32 page entries through the entry memory; a read
// or write hit passes the lookup, check and memory states, a read also the
// read wait state, and a page fault first scans the frames, one per cycle,
// up to 32. One command is in flight at a time; the result strobe is a
// single cycle and the receiver cannot stall it. After reset the byte memory
// and the page entries are cleared while busy is high.
module demand_paging_frame_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [2:0]  proc_id,
	input  logic [9:0]  virt_address,
	input  logic [10:0] request_size,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [2:0]  new_proc_id,
	output logic [7:0]  read_data
);
	import dpfa_pkg::*;

	// One-hot controller states.
	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_WALK   = 8'b0000_0100,
		S_LOOK   = 8'b0000_1000,
		S_CHK    = 8'b0001_0000,
		S_SCAN   = 8'b0010_0000,
		S_MEM    = 8'b0100_0000,
		S_RDWAIT = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Process bookkeeping lives in flops; both tables are tiny.
	logic [PROCESS_SLOTS-1:0] running_q;
	logic [10:0]              bytes_q [PROCESS_SLOTS];
	logic [FRAMES-1:0]        frame_used_q;
	logic [5:0]               reserved_q;

	// The accepted transaction.
	logic [1:0]         cmd_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [9:0]         addr_q;
	logic [7:0]         data_q;
	logic [FRAME_W-1:0] frame_q;
	logic [5:0]         cnt_q;
	logic [PHYS_AW-1:0] clr_q;

	// Entry walk pipeline: an entry read issued in one cycle returns in the next.
	logic              vld_s1;
	logic [PAGE_W-1:0] page_s1;

	logic        done_q;
	logic [1:0]  status_q;
	logic [2:0]  new_id_q;
	logic [7:0]  rdata_q;

	// Memory ports.
	logic              ent_we;
	logic [ENT_AW-1:0] ent_waddr, ent_raddr;
	entry_t            ent_wdata, ent_rdata;
	logic               phys_we;
	logic [PHYS_AW-1:0] phys_waddr, phys_raddr;
	logic [7:0]         phys_wdata, phys_rdata;

	// Create sizing: pages needed and room against the reservation.
	logic [11:0]       size_round;
	logic [5:0]        need;
	logic [6:0]        reserve_sum;
	logic              create_fits;
	logic              slot_found;
	logic [SLOT_W-1:0] free_slot;
	logic [11:0]       held_round;
	logic [5:0]        held;
	logic [PAGE_W-1:0] page;

	// Only sizes up to the virtual space are accepted, so six bits of page
	// count are enough wherever the count matters.
	assign size_round  = {1'b0, request_size} + 12'(PAGE_BYTES - 1);
	assign need        = size_round[OFF_W+5:OFF_W];
	assign reserve_sum = {1'b0, reserved_q} + {1'b0, need};
	assign create_fits = (request_size <= 11'(VIRTUAL_BYTES)) && (reserve_sum <= 7'(FRAMES));
	assign held_round  = {1'b0, bytes_q[proc_id]} + 12'(PAGE_BYTES - 1);
	assign held        = held_round[OFF_W+5:OFF_W];
	assign page        = addr_q[9:OFF_W];

	// Lowest free process slot.
	always_comb begin
		slot_found = 1'b0;
		free_slot  = '0;
		for (int s = PROCESS_SLOTS - 1; s >= 0; s--) begin
			if (!running_q[s]) begin
				slot_found = 1'b1;
				free_slot  = SLOT_W'(s);
			end
		end
	end

	// Entry memory access: the clearing pass after reset zeroes every entry;
	// the walk reads entry cnt_q and clears the entry whose read has returned
	// (page_s1); a lookup reads the addressed page; a fault fills it.
	always_comb begin
		ent_raddr = (state_q == S_WALK) ? {slot_q, cnt_q[PAGE_W-1:0]} : {slot_q, page};
		ent_we    = 1'b0;
		ent_waddr = {slot_q, page};
		ent_wdata = '0;
		if (state_q == S_CLEAR) begin
			ent_we    = 1'b1;
			ent_waddr = clr_q[ENT_AW-1:0];
		end else if (state_q == S_WALK && vld_s1) begin
			ent_we    = 1'b1;
			ent_waddr = {slot_q, page_s1};
		end else if (state_q == S_SCAN && !cnt_q[5] && !frame_used_q[cnt_q[FRAME_W-1:0]]) begin
			ent_we    = 1'b1;
			ent_wdata = '{present: 1'b1, frame: cnt_q[FRAME_W-1:0]};
		end
	end

	// Byte memory: the clearing pass after reset, or a translated write.
	always_comb begin
		phys_raddr = {frame_q, addr_q[OFF_W-1:0]};
		phys_we    = 1'b0;
		phys_waddr = phys_raddr;
		phys_wdata = data_q;
		if (state_q == S_CLEAR) begin
			phys_we    = 1'b1;
			phys_waddr = clr_q;
			phys_wdata = '0;
		end else if (state_q == S_MEM && cmd_q == CMD_WRITE) begin
			phys_we = 1'b1;
		end
	end

	dpfa_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	dpfa_ram #(.WIDTH(8), .DEPTH(PHYSICAL_BYTES)) u_phys_ram (
		.clk   (clk),
		.we    (phys_we),
		.waddr (phys_waddr),
		.wdata (phys_wdata),
		.raddr (phys_raddr),
		.rdata (phys_rdata)
	);

	// Main controller. Results are registered so that done pulses for one cycle
	// while the controller is already back in idle and can take a new command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			running_q    <= '0;
			frame_used_q <= '0;
			reserved_q   <= '0;
			clr_q        <= '0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			done_q       <= 1'b0;
			for (int s = 0; s < PROCESS_SLOTS; s++) begin
				bytes_q[s] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q    <= command;
						addr_q   <= virt_address;
						data_q   <= write_data;
						cnt_q    <= '0;
						vld_s1   <= 1'b0;
						status_q <= STAT_OK;
						new_id_q <= '0;
						rdata_q  <= '0;
						if (command == CMD_CREATE) begin
							if (create_fits && slot_found) begin
								running_q[free_slot] <= 1'b1;
								bytes_q[free_slot]   <= request_size;
								reserved_q           <= reserve_sum[5:0];
								slot_q               <= free_slot;
								new_id_q             <= 3'(free_slot);
								state_q              <= S_WALK;
							end else begin
								status_q <= STAT_FULL;
								done_q   <= 1'b1;
							end
						end else if (!running_q[proc_id]) begin
							status_q <= STAT_BAD;
							done_q   <= 1'b1;
						end else if (command == CMD_EXIT) begin
							running_q[proc_id] <= 1'b0;
							bytes_q[proc_id]   <= '0;
							reserved_q <= (reserved_q >= held) ? reserved_q - held : '0;
							slot_q     <= proc_id;
							state_q    <= S_WALK;
						end else if ({1'b0, virt_address} >= bytes_q[proc_id]) begin
							status_q <= STAT_BAD;
							done_q   <= 1'b1;
						end else begin
							slot_q  <= proc_id;
							state_q <= S_LOOK;
						end
					end
				end
				S_WALK: begin
					vld_s1  <= !cnt_q[5];
					page_s1 <= cnt_q[PAGE_W-1:0];
					if (!cnt_q[5]) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (vld_s1 && ent_rdata.present) begin
						frame_used_q[ent_rdata.frame] <= 1'b0;
					end
					if (cnt_q[5] && !vld_s1) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LOOK: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (ent_rdata.present) begin
						frame_q <= ent_rdata.frame;
						state_q <= S_MEM;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// First fit: one frame tested per cycle, lowest first.
					if (cnt_q[5]) begin
						status_q <= STAT_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (!frame_used_q[cnt_q[FRAME_W-1:0]]) begin
						frame_used_q[cnt_q[FRAME_W-1:0]] <= 1'b1;
						frame_q <= cnt_q[FRAME_W-1:0];
						state_q <= S_MEM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MEM: begin
					if (cmd_q == CMD_WRITE) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RDWAIT;
					end
				end
				S_RDWAIT: begin
					rdata_q <= phys_rdata;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign new_proc_id = new_id_q;
	assign read_data   = rdata_q;

	// The reservation never exceeds the number of frames.
	a_reserve_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= 6'(FRAMES))
		else $error("reservation exceeds frame count");

	// A result never appears while the byte memory is being cleared.
	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done_q)
		else $error("result during clearing pass");

	// A taken command always leaves idle or reports at once.
	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> (done_q || state_q != S_IDLE))
		else $error("accepted command dropped");

	// A failed result carries zero read data and a zero new process id.
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != STAT_OK) |-> (rdata_q == 8'd0 && new_id_q == 3'd0))
		else $error("failed result carries data");

endmodule
